// ===== hdl/bmp24_gray_decoder_top_defines.svh =====
// Assertion macros shared by the bmp24 gray decoder RTL.
`ifndef BMP24_GRAY_DECODER_TOP_DEFINES_SVH
`define BMP24_GRAY_DECODER_TOP_DEFINES_SVH
`ifndef SYNTHESIS
// Check a condition at every clock edge outside reset.
`define BMPG_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error("bmpgray: assertion failed");
// Check that a condition holds in the cycle after its trigger.
`define BMPG_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("bmpgray: assertion failed");
`else
`define BMPG_ASSERT(lbl, prop)
`define BMPG_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// ===== hdl/bmpgray_pkg.sv =====
// Types and constants of the bmp24 gray decoder.
`default_nettype none
package bmpgray_pkg;

	// Image limits and header layout
	localparam int unsigned MAX_DIM      = 4096;
	localparam int unsigned HEADER_BYTES = 54;
	localparam int unsigned DIM_W        = 13;
	localparam int unsigned IDX_W        = 12;
	localparam int unsigned SUM_W        = 10;

	localparam logic [5:0] POS_SIG_END   = 6'd1;
	localparam logic [5:0] POS_WIDTH_END = 6'd21;
	localparam logic [5:0] POS_HGT_END   = 6'd25;
	localparam logic [5:0] POS_DEPTH_END = 6'd29;
	localparam logic [5:0] POS_COMP_END  = 6'd33;
	localparam logic [5:0] POS_LAST      = 6'(HEADER_BYTES - 1);

	localparam logic [7:0]  SIG_B     = 8'h42;
	localparam logic [7:0]  SIG_M     = 8'h4D;
	localparam logic [15:0] DEPTH_24  = 16'd24;

	// Divide by three: multiply by 683 and drop 11 bits (exact for sums up to 765)
	localparam logic [SUM_W-1:0] GRAY_RECIP = 10'd683;
	localparam int unsigned      GRAY_SHIFT = 11;

	// Result kinds
	localparam logic [1:0] KIND_PIXEL  = 2'd0;
	localparam logic [1:0] KIND_ACCEPT = 2'd1;
	localparam logic [1:0] KIND_REJECT = 2'd2;

	// Rejection causes
	localparam logic [2:0] ERR_NONE      = 3'd0;
	localparam logic [2:0] ERR_SIGNATURE = 3'd1;
	localparam logic [2:0] ERR_DEPTH     = 3'd2;
	localparam logic [2:0] ERR_COMPRESS  = 3'd3;
	localparam logic [2:0] ERR_TOO_LARGE = 3'd4;

	// Queue between parser and result stage
	localparam int unsigned QUEUE_DEPTH = 4;
	localparam int unsigned QPTR_W      = 2;
	localparam int unsigned QCNT_W      = 3;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       start_of_file;
	} in_t;

	typedef struct packed {
		logic [1:0]       kind;
		logic [7:0]       gray;
		logic [IDX_W-1:0] row_index;
		logic [IDX_W-1:0] col_index;
		logic [DIM_W-1:0] image_width;
		logic [DIM_W-1:0] image_height;
		logic [2:0]       error_code;
		logic             last_pixel;
	} out_t;

	// One classified event from the parser; sum is the raw channel total
	typedef struct packed {
		logic [1:0]       kind;
		logic [SUM_W-1:0] sum;
		logic [IDX_W-1:0] row;
		logic [IDX_W-1:0] col;
		logic [DIM_W-1:0] width;
		logic [DIM_W-1:0] height;
		logic [2:0]       error_code;
		logic             last;
	} job_t;

endpackage
`default_nettype wire

// ===== hdl/bmpgray_queue.sv =====
// Small register queue between the byte parser and the result stage.
`default_nettype none
`include "bmp24_gray_decoder_top_defines.svh"
module bmpgray_queue (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               push,
	input  wire bmpgray_pkg::job_t  push_job,
	output logic                    full,
	input  wire logic               pop,
	output logic                    valid,
	output bmpgray_pkg::job_t       pop_job
);

	bmpgray_pkg::job_t                     slot_q [bmpgray_pkg::QUEUE_DEPTH];
	logic [bmpgray_pkg::QPTR_W-1:0]        wr_ptr_q;
	logic [bmpgray_pkg::QPTR_W-1:0]        rd_ptr_q;
	logic [bmpgray_pkg::QCNT_W-1:0]        count_q;

	assign full    = (count_q == bmpgray_pkg::QCNT_W'(bmpgray_pkg::QUEUE_DEPTH));
	assign valid   = (count_q != '0);
	assign pop_job = slot_q[rd_ptr_q];

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	// Store the pushed event
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_job;
		end
	end

	`BMPG_ASSERT(a_count_range, count_q <= bmpgray_pkg::QCNT_W'(bmpgray_pkg::QUEUE_DEPTH))
	`BMPG_ASSERT(a_no_overflow, !(push && full && !pop))

endmodule
`default_nettype wire

// ===== hdl/bmpgray_front.sv =====
// Byte parser: header checks, dimension capture and pixel triple assembly.
`default_nettype none
`include "bmp24_gray_decoder_top_defines.svh"
module bmpgray_front (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_acc,
	input  wire bmpgray_pkg::in_t   in_data,
	output logic                    push,
	output bmpgray_pkg::job_t       job
);

	localparam logic [1:0] PH_IDLE   = 2'd0;
	localparam logic [1:0] PH_HEADER = 2'd1;
	localparam logic [1:0] PH_PIXEL  = 2'd2;
	localparam logic [1:0] PH_DONE   = 2'd3;

	localparam int unsigned DW = bmpgray_pkg::DIM_W;
	localparam int unsigned IW = bmpgray_pkg::IDX_W;
	localparam int unsigned SW = bmpgray_pkg::SUM_W;

	logic [1:0]    phase_q, phase_d;
	logic [5:0]    pos_q, pos_d;
	logic [31:0]   shift_q, shift_d;
	logic [DW-1:0] width_q, width_d, height_q, height_d;
	logic          wbig_q, wbig_d, hbig_q, hbig_d;
	logic [SW-1:0] sum_q, sum_d;
	logic [1:0]    cnt_q, cnt_d;
	logic [IW-1:0] row_q, row_d, col_q, col_d;
	logic [1:0]    pad_q, pad_d;

	logic [1:0]    cur_phase;
	logic [5:0]    cur_pos;
	logic [SW-1:0] cur_sum;
	logic [1:0]    cur_cnt;
	logic [IW-1:0] cur_row, cur_col;
	logic [1:0]    cur_pad;
	logic [31:0]   new_shift;
	logic          field_big;
	logic [DW-1:0] row_inc, col_inc;
	logic [SW-1:0] sum_next;
	logic          is_last;

	// Restart on start of file, then classify the byte
	always_comb begin
		logic sof;
		sof = in_data.start_of_file;

		cur_phase = sof ? PH_HEADER : phase_q;
		cur_pos   = sof ? '0 : pos_q;
		cur_sum   = sof ? '0 : sum_q;
		cur_cnt   = sof ? '0 : cnt_q;
		cur_row   = sof ? '0 : row_q;
		cur_col   = sof ? '0 : col_q;
		cur_pad   = sof ? '0 : pad_q;

		new_shift = {in_data.data_byte, shift_q[31:8]};
		field_big = (new_shift > 32'(bmpgray_pkg::MAX_DIM));
		row_inc   = {1'b0, cur_row} + 1'b1;
		col_inc   = {1'b0, cur_col} + 1'b1;
		sum_next  = cur_sum + SW'(in_data.data_byte);
		is_last   = (row_inc == height_q) && (col_inc == width_q);

		phase_d  = phase_q;
		pos_d    = pos_q;
		shift_d  = shift_q;
		width_d  = width_q;
		height_d = height_q;
		wbig_d   = wbig_q;
		hbig_d   = hbig_q;
		sum_d    = sum_q;
		cnt_d    = cnt_q;
		row_d    = row_q;
		col_d    = col_q;
		pad_d    = pad_q;
		push     = 1'b0;
		job      = '0;

		if (in_acc) begin
			phase_d = cur_phase;
			pos_d   = cur_pos;
			sum_d   = cur_sum;
			cnt_d   = cur_cnt;
			row_d   = cur_row;
			col_d   = cur_col;
			pad_d   = cur_pad;
			case (cur_phase)
				PH_HEADER: begin
					shift_d = new_shift;
					pos_d   = cur_pos + 1'b1;
					case (cur_pos)
						bmpgray_pkg::POS_SIG_END: begin
							if (new_shift[31:16] != {bmpgray_pkg::SIG_M, bmpgray_pkg::SIG_B}) begin
								phase_d        = PH_DONE;
								push           = 1'b1;
								job.kind       = bmpgray_pkg::KIND_REJECT;
								job.error_code = bmpgray_pkg::ERR_SIGNATURE;
							end
						end
						bmpgray_pkg::POS_WIDTH_END: begin
							width_d = new_shift[DW-1:0];
							wbig_d  = field_big;
						end
						bmpgray_pkg::POS_HGT_END: begin
							height_d = new_shift[DW-1:0];
							hbig_d   = field_big;
						end
						bmpgray_pkg::POS_DEPTH_END: begin
							if (new_shift[31:16] != bmpgray_pkg::DEPTH_24) begin
								phase_d        = PH_DONE;
								push           = 1'b1;
								job.kind       = bmpgray_pkg::KIND_REJECT;
								job.error_code = bmpgray_pkg::ERR_DEPTH;
							end
						end
						bmpgray_pkg::POS_COMP_END: begin
							if (new_shift != '0) begin
								phase_d        = PH_DONE;
								push           = 1'b1;
								job.kind       = bmpgray_pkg::KIND_REJECT;
								job.error_code = bmpgray_pkg::ERR_COMPRESS;
							end else if (wbig_q || hbig_q) begin
								phase_d        = PH_DONE;
								push           = 1'b1;
								job.kind       = bmpgray_pkg::KIND_REJECT;
								job.error_code = bmpgray_pkg::ERR_TOO_LARGE;
							end
						end
						bmpgray_pkg::POS_LAST: begin
							phase_d    = (width_q == '0 || height_q == '0) ? PH_DONE : PH_PIXEL;
							push       = 1'b1;
							job.kind   = bmpgray_pkg::KIND_ACCEPT;
							job.width  = width_q;
							job.height = height_q;
						end
						default: ;
					endcase
				end
				PH_PIXEL: begin
					if (cur_pad != '0) begin
						// Drop a row padding byte
						pad_d = cur_pad - 1'b1;
					end else if (cur_cnt == 2'd2) begin
						// Third channel completes a pixel
						push       = 1'b1;
						job.kind   = bmpgray_pkg::KIND_PIXEL;
						job.sum    = sum_next;
						job.row    = cur_row;
						job.col    = cur_col;
						job.width  = width_q;
						job.height = height_q;
						job.last   = is_last;
						sum_d      = '0;
						cnt_d      = '0;
						if (is_last) begin
							phase_d = PH_DONE;
						end else if (col_inc >= width_q) begin
							col_d = '0;
							row_d = row_inc[IW-1:0];
							pad_d = width_q[1:0];
						end else begin
							col_d = col_inc[IW-1:0];
						end
					end else begin
						sum_d = sum_next;
						cnt_d = cur_cnt + 1'b1;
					end
				end
				default: ;
			endcase
		end
	end

	// Hold parse state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_IDLE;
			pos_q    <= '0;
			shift_q  <= '0;
			width_q  <= '0;
			height_q <= '0;
			wbig_q   <= 1'b0;
			hbig_q   <= 1'b0;
			sum_q    <= '0;
			cnt_q    <= '0;
			row_q    <= '0;
			col_q    <= '0;
			pad_q    <= '0;
		end else begin
			phase_q  <= phase_d;
			pos_q    <= pos_d;
			shift_q  <= shift_d;
			width_q  <= width_d;
			height_q <= height_d;
			wbig_q   <= wbig_d;
			hbig_q   <= hbig_d;
			sum_q    <= sum_d;
			cnt_q    <= cnt_d;
			row_q    <= row_d;
			col_q    <= col_d;
			pad_q    <= pad_d;
		end
	end

	`BMPG_ASSERT_NEXT(a_sof_restart, in_acc && in_data.start_of_file, phase_q == PH_HEADER)
	`BMPG_ASSERT(a_push_needs_beat, !(push && !in_acc))

endmodule
`default_nettype wire

// ===== hdl/bmpgray_back.sv =====
// Result stage: turns queued events into output beats, dividing sums by three.
`default_nettype none
`include "bmp24_gray_decoder_top_defines.svh"
module bmpgray_back (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               job_valid,
	input  wire bmpgray_pkg::job_t  job,
	output logic                    pop,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output bmpgray_pkg::out_t       out_data
);

	localparam int unsigned PW = 2 * bmpgray_pkg::SUM_W;

	logic              valid_q;
	bmpgray_pkg::out_t data_q;
	logic [PW-1:0]     prod;
	logic              out_is_pixel;
	logic              out_is_reject;
	logic              out_has_dims;

	// Take a new event whenever the output register is free or draining
	assign pop       = job_valid && (!valid_q || out_ready);
	assign out_valid = valid_q;
	assign out_data  = data_q;

	assign prod = PW'(job.sum) * PW'(bmpgray_pkg::GRAY_RECIP);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (pop) begin
			valid_q <= 1'b1;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

	// Load the output beat
	always_ff @(posedge clk) begin
		if (pop) begin
			data_q.kind         <= job.kind;
			data_q.gray         <= prod[bmpgray_pkg::GRAY_SHIFT +: 8];
			data_q.row_index    <= job.row;
			data_q.col_index    <= job.col;
			data_q.image_width  <= job.width;
			data_q.image_height <= job.height;
			data_q.error_code   <= job.error_code;
			data_q.last_pixel   <= job.last;
		end
	end

	// Classify the held beat for the checks below
	assign out_is_pixel  = valid_q && (data_q.kind == bmpgray_pkg::KIND_PIXEL);
	assign out_is_reject = valid_q && (data_q.kind == bmpgray_pkg::KIND_REJECT);
	assign out_has_dims  = (data_q.image_width != '0) || (data_q.image_height != '0);

	`BMPG_ASSERT(a_pixel_no_error, !(out_is_pixel && data_q.error_code != bmpgray_pkg::ERR_NONE))
	`BMPG_ASSERT(a_reject_no_dims, !(out_is_reject && out_has_dims))

endmodule
`default_nettype wire

// ===== hdl/bmp24_gray_decoder_top.sv =====
// Top level of the streaming 24-bit BMP to gray pixel decoder.
//
// Input channel (in_valid/in_ready/in_data) carries one file byte per beat;
// start_of_file marks byte 0 and restarts parsing at any point. Output
// channel (out_valid/out_ready/out_data) carries header accept, header
// reject (with error_code) and gray pixel beats in file order.
// One byte is taken per cycle while the event queue is not full. A byte
// that produces a result is classified as it is taken and written into
// the event queue at its input beat; the result stage, which divides the
// channel sum by three with a small multiply, then pops it and loads the
// output register once that register is free or draining.
// A four-entry queue separates parser and result stage, so the parser keeps
// taking bytes while the receiver stalls; in_ready drops only once the
// queue is full. Padding bytes, pixel bytes that complete no pixel and
// header bytes other than the accepting or rejecting one produce no beat.
// Reset clears the parser to wait for a start of file and empties the queue
// and the output register; bytes before the first start of file are dropped.
`default_nettype none
module bmp24_gray_decoder_top (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire bmpgray_pkg::in_t   in_data,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output bmpgray_pkg::out_t       out_data
);

	logic              in_acc;
	logic              push;
	logic              q_full;
	logic              q_valid;
	logic              pop;
	bmpgray_pkg::job_t push_job;
	bmpgray_pkg::job_t pop_job;

	assign in_ready = !q_full;
	assign in_acc   = in_valid && in_ready;

	bmpgray_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_acc  (in_acc),
		.in_data (in_data),
		.push    (push),
		.job     (push_job)
	);

	bmpgray_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (push_job),
		.full     (q_full),
		.pop      (pop),
		.valid    (q_valid),
		.pop_job  (pop_job)
	);

	bmpgray_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_valid (q_valid),
		.job       (pop_job),
		.pop       (pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule
`default_nettype wire
